// ----- hw/rtl/telnet_option_refuser_line_assembler_unit_assert.svh -----
// assertion macros for the telnet option refuser line assembler
// used by the top level only, no other dependencies
`ifndef TELNET_OPTION_REFUSER_LINE_ASSEMBLER_UNIT_ASSERT_SVH
`define TELNET_OPTION_REFUSER_LINE_ASSEMBLER_UNIT_ASSERT_SVH
`ifndef SYNTH
// concurrent check, disabled while reset is active
`define TORA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// concurrent check, also active during reset
`define TORA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define TORA_ASSERT(lbl, clk, rst_n, prop, msg)
`define TORA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- hw/rtl/tora_pkg.sv -----
// shared types and constants for the telnet option refuser line assembler
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package tora_pkg;

    // telnet bytes
    localparam logic [7:0] BYTE_LF  = 8'h0a;
    localparam logic [7:0] BYTE_CR  = 8'h0d;
    localparam logic [7:0] CMD_IAC  = 8'd255;
    localparam logic [7:0] CMD_WILL = 8'd251;
    localparam logic [7:0] CMD_WONT = 8'd252;
    localparam logic [7:0] CMD_DO   = 8'd253;
    localparam logic [7:0] CMD_DONT = 8'd254;

    // result kinds
    localparam logic [1:0] KIND_CHAR  = 2'd0;
    localparam logic [1:0] KIND_EOL   = 2'd1;
    localparam logic [1:0] KIND_REPLY = 2'd2;

    // reply byte index
    localparam logic [1:0] REPLY_IDX_IAC  = 2'd0;
    localparam logic [1:0] REPLY_IDX_VERB = 2'd1;
    localparam logic [1:0] REPLY_IDX_OPT  = 2'd2;

    // one group of results caused by one received byte
    typedef struct packed {
        logic       is_reply;  // three reply bytes, else one line result
        logic [1:0] kind;
        logic [7:0] value;     // line character, or option for a reply
        logic [6:0] len;
        logic [7:0] verb;
    } t_grp;

endpackage
`default_nettype wire

// ----- hw/rtl/tora_if.sv -----
// valid/ready channel interfaces for received bytes and results
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none
interface tora_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface tora_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] value;
    logic [6:0] line_length;
    logic       last;
    modport source (output valid, output kind, output value, output line_length,
                    output last, input ready);
    modport sink (input valid, input kind, input value, input line_length,
                  input last, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/tora_parser.sv -----
// input register, telnet parse state and line position, result group decode
// depends on tora_pkg
`timescale 1ns / 1ps
`default_nettype none
module tora_parser
    import tora_pkg::*;
#(
    parameter int LINE_CAPACITY = 80
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_grp_valid,
    input  wire logic       i_grp_ready,
    output t_grp            o_grp
);

    localparam int PW = (LINE_CAPACITY > 2) ? $clog2(LINE_CAPACITY) : 1;

    localparam logic [2:0] MODE_NORMAL = 3'd0;
    localparam logic [2:0] MODE_IAC    = 3'd1;
    localparam logic [2:0] MODE_WILL   = 3'd2;
    localparam logic [2:0] MODE_WONT   = 3'd3;
    localparam logic [2:0] MODE_DO     = 3'd4;
    localparam logic [2:0] MODE_DONT   = 3'd5;

    logic          r_in_valid;
    logic [7:0]    r_in_byte;
    logic [2:0]    r_mode;
    logic [PW-1:0] r_pos;
    logic [2:0]    n_mode;
    logic [PW-1:0] n_pos;

    logic          d_has;
    t_grp          d_grp;
    logic [PW-1:0] d_pos;
    logic          has_out;
    t_grp          grp;
    logic          advance;

    // line rules for a data byte
    always_comb begin
        d_has          = 1'b1;
        d_grp          = '0;
        d_grp.is_reply = 1'b0;
        d_pos          = r_pos;
        if (r_in_byte == BYTE_CR) begin
            d_has = 1'b0;
        end else if (r_in_byte == BYTE_LF || r_pos >= PW'(LINE_CAPACITY - 1)) begin
            d_grp.kind = KIND_EOL;
            d_grp.len  = 7'(r_pos);
            d_pos      = '0;
        end else begin
            d_grp.kind  = KIND_CHAR;
            d_grp.value = r_in_byte;
            d_pos       = r_pos + PW'(1);
        end
    end

    always_comb begin
        has_out = 1'b0;
        grp     = d_grp;
        n_mode  = MODE_NORMAL;
        n_pos   = r_pos;
        case (r_mode)
            MODE_IAC: begin
                case (r_in_byte)
                    CMD_IAC: begin
                        has_out = d_has;
                        n_pos   = d_pos;
                    end
                    CMD_WILL: n_mode = MODE_WILL;
                    CMD_WONT: n_mode = MODE_WONT;
                    CMD_DO:   n_mode = MODE_DO;
                    CMD_DONT: n_mode = MODE_DONT;
                    default:  n_mode = MODE_NORMAL;
                endcase
            end
            MODE_WILL, MODE_WONT, MODE_DO, MODE_DONT: begin
                has_out      = 1'b1;
                grp          = '0;
                grp.is_reply = 1'b1;
                grp.kind     = KIND_REPLY;
                grp.value    = r_in_byte;
                grp.verb     = (r_mode inside {MODE_WILL, MODE_WONT}) ? CMD_DONT : CMD_WONT;
            end
            default: begin
                if (r_in_byte == CMD_IAC) begin
                    n_mode = MODE_IAC;
                end else begin
                    has_out = d_has;
                    n_pos   = d_pos;
                end
            end
        endcase
    end

    assign advance     = r_in_valid && (!has_out || i_grp_ready);
    assign o_ready     = !r_in_valid || advance;
    assign o_grp_valid = r_in_valid && has_out;
    assign o_grp       = grp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= MODE_NORMAL;
            r_pos      <= '0;
        end else begin
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_mode <= n_mode;
                r_pos  <= n_pos;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_byte <= i_rx_byte;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/tora_emitter.sv -----
// result register: holds one result group and sends it out item by item
// depends on tora_pkg
`timescale 1ns / 1ps
`default_nettype none
module tora_emitter
    import tora_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_grp_valid,
    output logic            o_grp_ready,
    input  wire t_grp       i_grp,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [1:0]      o_kind,
    output logic [7:0]      o_value,
    output logic [6:0]      o_line_length,
    output logic            o_last
);

    logic       r_valid;
    logic [1:0] r_idx;
    t_grp       r_grp;
    logic       load;
    logic       xfer;

    always_comb begin
        if (r_grp.is_reply) begin
            o_kind        = KIND_REPLY;
            o_line_length = '0;
            o_last        = (r_idx == REPLY_IDX_OPT);
            case (r_idx)
                REPLY_IDX_IAC:  o_value = CMD_IAC;
                REPLY_IDX_VERB: o_value = r_grp.verb;
                default:        o_value = r_grp.value;
            endcase
        end else begin
            o_kind        = r_grp.kind;
            o_value       = r_grp.value;
            o_line_length = r_grp.len;
            o_last        = 1'b1;
        end
    end

    assign o_valid     = r_valid;
    assign xfer        = r_valid && i_ready;
    assign o_grp_ready = !r_valid || (xfer && o_last);
    assign load        = i_grp_valid && o_grp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= REPLY_IDX_IAC;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= REPLY_IDX_IAC;
        end else if (xfer) begin
            if (o_last) begin
                r_valid <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_grp <= i_grp;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/telnet_option_refuser_line_assembler_unit.sv -----
// path: a received byte goes through the input register and then the result register
// throughput: one byte per cycle while results are taken; a negotiation reply holds
//   the result register until all three reply bytes have left, one at a time
// reset (synchronous, active low): parse mode normal, line position zero,
//   input and result registers empty
`timescale 1ns / 1ps
`default_nettype none
`include "telnet_option_refuser_line_assembler_unit_assert.svh"
module telnet_option_refuser_line_assembler_unit
    import tora_pkg::*;
#(
    parameter int LINE_CAPACITY = 80
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tora_in_if.sink    i_in,
    tora_out_if.source o_out
);

    // handoff between the parse stage and the result register
    logic grp_valid;
    logic grp_ready;
    t_grp grp;

    // parse stage: input register, mode and line position, one decode per byte;
    // a byte that causes no result retires without touching the result register
    tora_parser #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_rx_byte   (i_in.rx_byte),
        .o_grp_valid (grp_valid),
        .i_grp_ready (grp_ready),
        .o_grp       (grp)
    );

    // result register: a line result leaves in one transfer, a reply
    // (iac, verb, option) in three; it refills in the cycle the last one leaves
    tora_emitter u_emitter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_grp_valid   (grp_valid),
        .o_grp_ready   (grp_ready),
        .i_grp         (grp),
        .o_valid       (o_out.valid),
        .i_ready       (o_out.ready),
        .o_kind        (o_out.kind),
        .o_value       (o_out.value),
        .o_line_length (o_out.line_length),
        .o_last        (o_out.last)
    );

    // end of line carries no character
    `TORA_ASSERT(a_eol_value_zero, i_clk, i_rst_n,
        o_out.valid && o_out.kind == KIND_EOL |-> o_out.value == 8'd0,
        "end of line with nonzero value")
    // line results are always the only result of their byte
    `TORA_ASSERT(a_line_is_last, i_clk, i_rst_n,
        o_out.valid && o_out.kind != KIND_REPLY |-> o_out.last,
        "line result without last")
    // a reply is never broken up: the next reply byte follows at once
    `TORA_ASSERT(a_reply_contiguous, i_clk, i_rst_n,
        o_out.valid && o_out.ready && o_out.kind == KIND_REPLY && !o_out.last
            |=> o_out.valid && o_out.kind == KIND_REPLY,
        "reply sequence broken")
    // nothing goes out in the first cycle after reset is released
    `TORA_ASSERT(a_reset_empty, i_clk, i_rst_n,
        !$past(i_rst_n) |-> !o_out.valid,
        "result valid after reset")

endmodule
`default_nettype wire
